[design/hrp_pkg.sv]
// Shared types, character codes and command encodings of the HTTP request header parser.
package hrp_pkg;

    localparam int Q_DEPTH = 4;

    localparam logic [1:0] MODE_REQ  = 2'd0;
    localparam logic [1:0] MODE_HDR  = 2'd1;
    localparam logic [1:0] MODE_READ = 2'd2;
    localparam logic [1:0] MODE_NOP  = 2'd3;

    localparam logic [1:0] ST_PARSED  = 2'd0;
    localparam logic [1:0] ST_HDR_END = 2'd1;
    localparam logic [1:0] ST_ERROR   = 2'd2;

    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_SP      = 8'h20;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_TAB     = 8'h09;

    typedef enum logic [2:0] {
        FLD_METHOD  = 3'd0,
        FLD_URL     = 3'd1,
        FLD_VERSION = 3'd2,
        FLD_KEY     = 3'd3,
        FLD_VALUE   = 3'd4
    } t_field;

    typedef enum logic [1:0] {
        CMD_WRITE  = 2'd0,
        CMD_READ   = 2'd1,
        CMD_STATUS = 2'd2
    } t_cmd_kind;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] char_in;
        logic       line_start;
        logic       end_of_line;
        logic [2:0] read_field;
        logic [3:0] read_header;
        logic [7:0] read_pos;
    } t_in_word;

    typedef struct packed {
        logic       result_kind;
        logic [1:0] status;
        logic [4:0] hdr_total;
        logic [7:0] field_length;
        logic [7:0] read_char;
    } t_out_word;

    // One command from the parser to the store side.
    typedef struct packed {
        t_cmd_kind  kind;
        t_field     target;
        logic [5:0] slot;
        logic [11:0] idx;
        logic [7:0] data;
        logic       rd_ok;
        t_out_word  word;
    } t_cmd;

endpackage

[design/http_request_header_parser.sv]
// Top level of the HTTP request line and header parser.
// Throughput: one word per cycle on both sides, sustained, when pop keeps up.
// A result reaches o_data after its word is accepted by way of the command queue,
// the store read stage and then the result queue.
// Reset (synchronous, active low) empties both queues, idles the parser and clears
// all lengths and the header count; store contents stay undefined until written.
module http_request_header_parser #(
    parameter int METHOD_BYTES  = 16,
    parameter int URL_BYTES     = 256,
    parameter int VERSION_BYTES = 16,
    parameter int KEY_BYTES     = 64,
    parameter int VALUE_BYTES   = 256,
    parameter int HEADER_SLOTS  = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  hrp_pkg::t_in_word  i_data,
    input  logic               pop,
    output logic               empty,
    output hrp_pkg::t_out_word o_data
);
    localparam int CMDW = $bits(hrp_pkg::t_cmd);
    localparam int QCW  = $clog2(hrp_pkg::Q_DEPTH + 1);

    logic          accept, cmd_valid, cmdq_empty, cmd_pop;
    hrp_pkg::t_cmd cmd_in, cmd_head;
    logic [CMDW-1:0] cmdq_bits;
    logic [QCW-1:0]  cmdq_cnt;

    // A word is taken whenever the command queue has room; the parser itself never stalls.
    assign accept = push && !full;

    hrp_front #(
        .METHOD_BYTES(METHOD_BYTES), .URL_BYTES(URL_BYTES),
        .VERSION_BYTES(VERSION_BYTES), .KEY_BYTES(KEY_BYTES),
        .VALUE_BYTES(VALUE_BYTES), .HEADER_SLOTS(HEADER_SLOTS)
    ) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_accept(accept), .i_word(i_data),
        .o_cmd_valid(cmd_valid), .o_cmd(cmd_in));

    // The command queue decouples parsing from the stores so that either may stall alone.
    hrp_fifo #(.W(CMDW), .DEPTH(hrp_pkg::Q_DEPTH)) u_cmdq (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(cmd_valid), .i_data(cmd_in),
        .o_full(full), .i_pop(cmd_pop), .o_data(cmdq_bits), .o_empty(cmdq_empty),
        .o_count(cmdq_cnt));

    assign cmd_head = hrp_pkg::t_cmd'(cmdq_bits);

    hrp_back #(
        .METHOD_BYTES(METHOD_BYTES), .URL_BYTES(URL_BYTES),
        .VERSION_BYTES(VERSION_BYTES), .KEY_BYTES(KEY_BYTES),
        .VALUE_BYTES(VALUE_BYTES), .HEADER_SLOTS(HEADER_SLOTS)
    ) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd_empty(cmdq_empty), .i_cmd(cmd_head),
        .o_cmd_pop(cmd_pop), .i_pop(pop), .o_empty(empty), .o_word(o_data));

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> (cmdq_cnt == QCW'(hrp_pkg::Q_DEPTH)))
        else $error("command queue full flag disagrees with its count");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_pop |-> !cmdq_empty)
        else $error("command taken from an empty queue");
    a_accept_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && cmd_valid) |=> (cmdq_cnt != '0))
        else $error("accepted command did not reach the queue");
endmodule

[design/hrp_ram.sv]
// Generic single-port RAM with registered read data.
module hrp_ram #(
    parameter int W     = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_addr,
    input  logic [W-1:0]  i_wdata,
    output logic [W-1:0]  o_rdata
);
    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

[design/hrp_fifo.sv]
// Small register queue used between the parser and the stores and at the result side.
module hrp_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 4,
    localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNTW = $clog2(DEPTH + 1)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  logic [W-1:0]    i_data,
    output logic            o_full,
    input  logic            i_pop,
    output logic [W-1:0]    o_data,
    output logic            o_empty,
    output logic [CNTW-1:0] o_count
);
    logic [W-1:0]    r_mem [DEPTH];
    logic [PW-1:0]   r_rd, r_wr;
    logic [CNTW-1:0] r_cnt;
    logic            do_push, do_pop;

    assign o_full  = (r_cnt == CNTW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_count = r_cnt;
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
        if (!i_rst_n) begin
            r_rd  <= '0;
            r_wr  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            r_cnt <= r_cnt + CNTW'(do_push) - CNTW'(do_pop);
        end
    end
endmodule

[design/hrp_front.sv]
// Line parser: keeps the phase, indexes and lengths and turns accepted words into write, read and status commands.
module hrp_front #(
    parameter int METHOD_BYTES  = 16,
    parameter int URL_BYTES     = 256,
    parameter int VERSION_BYTES = 16,
    parameter int KEY_BYTES     = 64,
    parameter int VALUE_BYTES   = 256,
    parameter int HEADER_SLOTS  = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  hrp_pkg::t_in_word i_word,
    output logic              o_cmd_valid,
    output hrp_pkg::t_cmd     o_cmd
);
    localparam int MAXB1 = (METHOD_BYTES > URL_BYTES) ? METHOD_BYTES : URL_BYTES;
    localparam int MAXB2 = (VERSION_BYTES > KEY_BYTES) ? VERSION_BYTES : KEY_BYTES;
    localparam int MAXB3 = (MAXB1 > MAXB2) ? MAXB1 : MAXB2;
    localparam int MAXB  = (MAXB3 > VALUE_BYTES) ? MAXB3 : VALUE_BYTES;
    localparam int CW    = $clog2(MAXB);
    localparam int SW    = (HEADER_SLOTS > 1) ? $clog2(HEADER_SLOTS) : 1;
    localparam int HW    = $clog2(HEADER_SLOTS + 1);

    typedef enum logic [11:0] {
        PH_IDLE     = 12'b0000_0000_0001,
        PH_METHOD   = 12'b0000_0000_0010,
        PH_URL      = 12'b0000_0000_0100,
        PH_VERSION  = 12'b0000_0000_1000,
        PH_REQ_DONE = 12'b0000_0001_0000,
        PH_KEY      = 12'b0000_0010_0000,
        PH_VALUE    = 12'b0000_0100_0000,
        PH_SAW_CR   = 12'b0000_1000_0000,
        PH_SAW_LF   = 12'b0001_0000_0000,
        PH_HDR_DONE = 12'b0010_0000_0000,
        PH_HDR_END  = 12'b0100_0000_0000,
        PH_ERROR    = 12'b1000_0000_0000
    } t_phase;

    t_phase        r_phase, n_phase;
    logic [CW-1:0] r_ci, n_ci, r_nb, n_nb;
    logic [CW-1:0] r_mlen, n_mlen, r_ulen, n_ulen, r_vlen, n_vlen;
    logic [CW-1:0] r_klen [HEADER_SLOTS];
    logic [CW-1:0] n_klen [HEADER_SLOTS];
    logic [CW-1:0] r_valen [HEADER_SLOTS];
    logic [CW-1:0] n_valen [HEADER_SLOTS];
    logic [HW-1:0] r_hdrs, n_hdrs;

    logic          feed, cmd_v, slot_ok;
    hrp_pkg::t_cmd cmd;
    logic [7:0]    c;
    logic [SW-1:0] wslot, rslot;
    logic [CW-1:0] rlen;

    always_comb begin
        n_phase = r_phase;
        n_ci    = r_ci;
        n_nb    = r_nb;
        n_mlen  = r_mlen;
        n_ulen  = r_ulen;
        n_vlen  = r_vlen;
        n_klen  = r_klen;
        n_valen = r_valen;
        n_hdrs  = r_hdrs;
        feed    = 1'b0;
        cmd_v   = 1'b0;
        cmd     = '0;
        c       = i_word.char_in;
        rslot   = SW'(i_word.read_header);
        slot_ok = (32'(i_word.read_header) < 32'(r_hdrs))
                  && (32'(i_word.read_header) < HEADER_SLOTS);
        rlen    = '0;
        wslot   = SW'(r_hdrs);
        if (i_accept) begin
            case (i_word.mode)
                hrp_pkg::MODE_READ: begin
                    cmd_v      = 1'b1;
                    cmd.kind   = hrp_pkg::CMD_READ;
                    cmd.target = hrp_pkg::t_field'(i_word.read_field);
                    cmd.slot   = 6'(i_word.read_header);
                    cmd.idx    = 12'(i_word.read_pos);
                    case (i_word.read_field)
                        hrp_pkg::FLD_METHOD: rlen = r_mlen;
                        hrp_pkg::FLD_URL: rlen = r_ulen;
                        hrp_pkg::FLD_VERSION: rlen = r_vlen;
                        hrp_pkg::FLD_KEY: rlen = slot_ok ? r_klen[rslot] : '0;
                        hrp_pkg::FLD_VALUE: rlen = slot_ok ? r_valen[rslot] : '0;
                        default: rlen = '0;
                    endcase
                    cmd.rd_ok = 32'(i_word.read_pos) < 32'(rlen);
                    cmd.word.result_kind  = 1'b1;
                    cmd.word.status       = hrp_pkg::ST_PARSED;
                    cmd.word.hdr_total    = 5'(r_hdrs);
                    cmd.word.field_length = 8'(32'(rlen));
                end
                hrp_pkg::MODE_REQ, hrp_pkg::MODE_HDR: begin
                    if (i_word.line_start) begin
                        n_ci = '0;
                        n_nb = '0;
                        if (i_word.mode == hrp_pkg::MODE_REQ) begin
                            n_mlen  = '0;
                            n_ulen  = '0;
                            n_vlen  = '0;
                            n_hdrs  = '0;
                            for (int i = 0; i < HEADER_SLOTS; i++) begin
                                n_klen[i]  = '0;
                                n_valen[i] = '0;
                            end
                            n_phase = PH_METHOD;
                            feed    = !i_word.end_of_line;
                        end else if (!i_word.end_of_line
                                     && (c == hrp_pkg::CH_CR || c == hrp_pkg::CH_LF)) begin
                            n_phase = PH_HDR_END;
                        end else if (32'(r_hdrs) >= HEADER_SLOTS) begin
                            n_phase = PH_ERROR;
                        end else begin
                            n_klen[wslot] = '0;
                            n_phase = PH_KEY;
                            feed    = !i_word.end_of_line;
                        end
                    end else begin
                        feed = !i_word.end_of_line;
                    end

                    if (feed) begin
                        cmd.kind = hrp_pkg::CMD_WRITE;
                        cmd.slot = 6'(wslot);
                        cmd.idx  = 12'(n_ci);
                        cmd.data = c;
                        case (n_phase)
                            PH_METHOD: begin
                                if (c != hrp_pkg::CH_SP) begin
                                    if (c >= hrp_pkg::CH_UPPER_A && c <= hrp_pkg::CH_UPPER_Z
                                        && 32'(n_ci) < METHOD_BYTES - 1) begin
                                        cmd_v      = 1'b1;
                                        cmd.target = hrp_pkg::FLD_METHOD;
                                        n_ci       = n_ci + CW'(1);
                                        n_mlen     = n_ci;
                                    end else begin
                                        n_phase = PH_ERROR;
                                    end
                                end else if (n_ci != '0) begin
                                    n_phase = PH_URL;
                                    n_ci    = '0;
                                end
                            end
                            PH_URL: begin
                                if (c != hrp_pkg::CH_SP) begin
                                    if (32'(n_ci) < URL_BYTES - 1) begin
                                        cmd_v      = 1'b1;
                                        cmd.target = hrp_pkg::FLD_URL;
                                        n_ci       = n_ci + CW'(1);
                                        n_ulen     = n_ci;
                                    end else begin
                                        n_phase = PH_ERROR;
                                    end
                                end else if (n_ci != '0) begin
                                    n_phase = PH_VERSION;
                                    n_ci    = '0;
                                end
                            end
                            PH_VERSION: begin
                                if (c == hrp_pkg::CH_CR || c == hrp_pkg::CH_LF) begin
                                    n_phase = PH_REQ_DONE;
                                end else if (32'(n_ci) < VERSION_BYTES - 1) begin
                                    if (c != hrp_pkg::CH_SP) begin
                                        cmd_v      = 1'b1;
                                        cmd.target = hrp_pkg::FLD_VERSION;
                                        n_ci       = n_ci + CW'(1);
                                        n_vlen     = n_ci;
                                    end
                                end else begin
                                    n_phase = PH_ERROR;
                                end
                            end
                            PH_KEY: begin
                                if (c == hrp_pkg::CH_SP || c == hrp_pkg::CH_CR
                                    || c == hrp_pkg::CH_LF) begin
                                    n_phase = PH_ERROR;
                                end else if (c == hrp_pkg::CH_COLON) begin
                                    if (n_ci == '0) begin
                                        n_phase = PH_ERROR;
                                    end else begin
                                        n_phase = PH_VALUE;
                                        n_ci    = '0;
                                        n_nb    = '0;
                                    end
                                end else if (32'(n_ci) < KEY_BYTES - 1) begin
                                    cmd_v         = 1'b1;
                                    cmd.target    = hrp_pkg::FLD_KEY;
                                    n_ci          = n_ci + CW'(1);
                                    n_klen[wslot] = n_ci;
                                end else begin
                                    n_phase = PH_ERROR;
                                end
                            end
                            PH_VALUE: begin
                                if (c == hrp_pkg::CH_SP && n_ci == '0) begin
                                    n_phase = PH_VALUE;
                                end else if (c == hrp_pkg::CH_CR) begin
                                    n_phase = PH_SAW_CR;
                                end else if (c == hrp_pkg::CH_LF) begin
                                    n_phase = PH_SAW_LF;
                                end else if (32'(n_ci) < VALUE_BYTES - 1) begin
                                    cmd_v      = 1'b1;
                                    cmd.target = hrp_pkg::FLD_VALUE;
                                    n_ci       = n_ci + CW'(1);
                                    if (c != hrp_pkg::CH_SP && c != hrp_pkg::CH_TAB) begin
                                        n_nb = n_ci;
                                    end
                                end else begin
                                    n_phase = PH_ERROR;
                                end
                            end
                            PH_SAW_CR: begin
                                if (c == hrp_pkg::CH_LF) begin
                                    n_valen[wslot] = n_nb;
                                    n_phase = PH_HDR_DONE;
                                end else begin
                                    n_phase = PH_ERROR;
                                end
                            end
                            PH_SAW_LF: begin
                                if (c == hrp_pkg::CH_CR) begin
                                    n_phase = PH_ERROR;
                                end else begin
                                    n_valen[wslot] = n_nb;
                                    n_phase = PH_HDR_DONE;
                                end
                            end
                            default: n_phase = n_phase;
                        endcase
                    end

                    if (i_word.end_of_line) begin
                        cmd_v    = 1'b1;
                        cmd      = '0;
                        cmd.kind = hrp_pkg::CMD_STATUS;
                        // A value closed by a bare LF is only known good at the terminator.
                        if (n_phase == PH_SAW_LF) begin
                            n_valen[wslot] = n_nb;
                            n_phase = PH_HDR_DONE;
                        end
                        case (n_phase)
                            PH_REQ_DONE: cmd.word.status = hrp_pkg::ST_PARSED;
                            PH_HDR_DONE: begin
                                if (32'(n_hdrs) < HEADER_SLOTS) begin
                                    n_hdrs = n_hdrs + HW'(1);
                                end
                                cmd.word.status = hrp_pkg::ST_PARSED;
                            end
                            PH_HDR_END: cmd.word.status = hrp_pkg::ST_HDR_END;
                            default: cmd.word.status = hrp_pkg::ST_ERROR;
                        endcase
                        cmd.word.hdr_total = 5'(n_hdrs);
                        n_phase = PH_IDLE;
                        n_ci    = '0;
                        n_nb    = '0;
                    end
                end
                default: cmd_v = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_ci    <= '0;
            r_nb    <= '0;
            r_mlen  <= '0;
            r_ulen  <= '0;
            r_vlen  <= '0;
            r_hdrs  <= '0;
            for (int i = 0; i < HEADER_SLOTS; i++) begin
                r_klen[i]  <= '0;
                r_valen[i] <= '0;
            end
        end else begin
            r_phase <= n_phase;
            r_ci    <= n_ci;
            r_nb    <= n_nb;
            r_mlen  <= n_mlen;
            r_ulen  <= n_ulen;
            r_vlen  <= n_vlen;
            r_hdrs  <= n_hdrs;
            r_klen  <= n_klen;
            r_valen <= n_valen;
        end
    end

    assign o_cmd_valid = cmd_v;
    assign o_cmd       = cmd;

    a_idle_after_eol: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_word.end_of_line && (i_word.mode == hrp_pkg::MODE_REQ
            || i_word.mode == hrp_pkg::MODE_HDR)) |=> (r_phase == PH_IDLE))
        else $error("parser not idle after a line terminator");
    a_hdr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_hdrs) <= HEADER_SLOTS)
        else $error("stored header count beyond slot count");
endmodule

[design/hrp_back.sv]
// Store side: executes store writes and reads and queues the result words.
module hrp_back #(
    parameter int METHOD_BYTES  = 16,
    parameter int URL_BYTES     = 256,
    parameter int VERSION_BYTES = 16,
    parameter int KEY_BYTES     = 64,
    parameter int VALUE_BYTES   = 256,
    parameter int HEADER_SLOTS  = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_empty,
    input  hrp_pkg::t_cmd      i_cmd,
    output logic               o_cmd_pop,
    input  logic               i_pop,
    output logic               o_empty,
    output hrp_pkg::t_out_word o_word
);
    localparam int SW   = (HEADER_SLOTS > 1) ? $clog2(HEADER_SLOTS) : 1;
    localparam int MAW  = (METHOD_BYTES > 1) ? $clog2(METHOD_BYTES) : 1;
    localparam int UAW  = (URL_BYTES > 1) ? $clog2(URL_BYTES) : 1;
    localparam int VAW  = (VERSION_BYTES > 1) ? $clog2(VERSION_BYTES) : 1;
    localparam int KAW  = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
    localparam int LAW  = (VALUE_BYTES > 1) ? $clog2(VALUE_BYTES) : 1;
    localparam int OW   = $bits(hrp_pkg::t_out_word);
    localparam int QCW  = $clog2(hrp_pkg::Q_DEPTH + 1);

    logic [7:0]     m_rd, u_rd, v_rd, k_rd, l_rd;
    logic           we_m, we_u, we_v, we_k, we_l, is_wr;
    logic           r_s1_v, r_s1_ok;
    hrp_pkg::t_field    r_s1_tgt;
    hrp_pkg::t_out_word r_s1_word, s1_word;
    logic [QCW-1:0] out_cnt;
    logic           out_full;
    logic [OW-1:0]  out_bits;

    assign o_cmd_pop = !i_cmd_empty
                       && (32'(out_cnt) + 32'(r_s1_v) < hrp_pkg::Q_DEPTH);
    assign is_wr = o_cmd_pop && (i_cmd.kind == hrp_pkg::CMD_WRITE);
    assign we_m  = is_wr && (i_cmd.target == hrp_pkg::FLD_METHOD);
    assign we_u  = is_wr && (i_cmd.target == hrp_pkg::FLD_URL);
    assign we_v  = is_wr && (i_cmd.target == hrp_pkg::FLD_VERSION);
    assign we_k  = is_wr && (i_cmd.target == hrp_pkg::FLD_KEY);
    assign we_l  = is_wr && (i_cmd.target == hrp_pkg::FLD_VALUE);

    hrp_ram #(.W(8), .DEPTH(METHOD_BYTES)) u_method (
        .i_clk(i_clk), .i_we(we_m), .i_addr(i_cmd.idx[MAW-1:0]),
        .i_wdata(i_cmd.data), .o_rdata(m_rd));
    hrp_ram #(.W(8), .DEPTH(URL_BYTES)) u_url (
        .i_clk(i_clk), .i_we(we_u), .i_addr(i_cmd.idx[UAW-1:0]),
        .i_wdata(i_cmd.data), .o_rdata(u_rd));
    hrp_ram #(.W(8), .DEPTH(VERSION_BYTES)) u_version (
        .i_clk(i_clk), .i_we(we_v), .i_addr(i_cmd.idx[VAW-1:0]),
        .i_wdata(i_cmd.data), .o_rdata(v_rd));
    hrp_ram #(.W(8), .DEPTH(1 << (SW + KAW))) u_key (
        .i_clk(i_clk), .i_we(we_k), .i_addr({i_cmd.slot[SW-1:0], i_cmd.idx[KAW-1:0]}),
        .i_wdata(i_cmd.data), .o_rdata(k_rd));
    hrp_ram #(.W(8), .DEPTH(1 << (SW + LAW))) u_value (
        .i_clk(i_clk), .i_we(we_l), .i_addr({i_cmd.slot[SW-1:0], i_cmd.idx[LAW-1:0]}),
        .i_wdata(i_cmd.data), .o_rdata(l_rd));

    always_ff @(posedge i_clk) begin
        r_s1_word <= i_cmd.word;
        r_s1_ok   <= i_cmd.rd_ok && (i_cmd.kind == hrp_pkg::CMD_READ);
        r_s1_tgt  <= i_cmd.target;
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else begin
            r_s1_v <= o_cmd_pop && (i_cmd.kind != hrp_pkg::CMD_WRITE);
        end
    end

    always_comb begin
        s1_word = r_s1_word;
        if (r_s1_ok) begin
            case (r_s1_tgt)
                hrp_pkg::FLD_METHOD: s1_word.read_char = m_rd;
                hrp_pkg::FLD_URL: s1_word.read_char = u_rd;
                hrp_pkg::FLD_VERSION: s1_word.read_char = v_rd;
                hrp_pkg::FLD_KEY: s1_word.read_char = k_rd;
                hrp_pkg::FLD_VALUE: s1_word.read_char = l_rd;
                default: s1_word.read_char = '0;
            endcase
        end
    end

    hrp_fifo #(.W(OW), .DEPTH(hrp_pkg::Q_DEPTH)) u_outq (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(r_s1_v), .i_data(s1_word),
        .o_full(out_full), .i_pop(i_pop), .o_data(out_bits), .o_empty(o_empty),
        .o_count(out_cnt));

    assign o_word = hrp_pkg::t_out_word'(out_bits);

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_v |-> !out_full)
        else $error("result queue overflow");
    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd_pop && i_cmd.kind == hrp_pkg::CMD_WRITE) |=> !r_s1_v)
        else $error("store write produced a result word");
    a_read_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd_pop && i_cmd.kind == hrp_pkg::CMD_READ) |=> (r_s1_v && r_s1_word.result_kind))
        else $error("read command lost or mislabelled");
    a_gated_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_v && !r_s1_ok) |-> (s1_word.read_char == 8'd0))
        else $error("out-of-range read returned data");
endmodule

[tb/sv/hrp_line_checker.sv]
// Watches both channels of the parser, predicts each result and compares it.
module hrp_line_checker
    import hrp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  logic      i_full,
    input  t_in_word  i_in,
    input  logic      i_pop,
    input  logic      i_empty,
    input  t_out_word i_out,
    output int        o_errors,
    output int        o_waiting
);

    localparam int N_METHOD = 16;
    localparam int N_URL    = 256;
    localparam int N_VER    = 16;
    localparam int N_KEY    = 64;
    localparam int N_VAL    = 256;
    localparam int N_SLOTS  = 16;

    typedef enum int {
        P_IDLE, P_METHOD, P_URL, P_VERSION, P_REQ_DONE, P_KEY, P_VALUE,
        P_SAW_CR, P_SAW_LF, P_HDR_DONE, P_HDR_END, P_ERROR
    } t_phase;

    t_phase    phase;
    int        pos_idx;
    int        nonblank;
    logic [7:0] method_mem [N_METHOD];
    logic [7:0] url_mem    [N_URL];
    logic [7:0] ver_mem    [N_VER];
    logic [7:0] key_mem    [N_SLOTS*N_KEY];
    logic [7:0] val_mem    [N_SLOTS*N_VAL];
    int        method_len, url_len, ver_len, hdr_count;
    int        key_len [N_SLOTS];
    int        val_len [N_SLOTS];
    t_out_word expected_words [$];

    assign o_waiting = expected_words.size();

    function automatic void clear_model();
        phase = P_IDLE;
        pos_idx = 0;
        nonblank = 0;
        method_len = 0;
        url_len = 0;
        ver_len = 0;
        hdr_count = 0;
        foreach (key_len[i]) begin
            key_len[i] = 0;
            val_len[i] = 0;
        end
        foreach (method_mem[i]) method_mem[i] = '0;
        foreach (url_mem[i]) url_mem[i] = '0;
        foreach (ver_mem[i]) ver_mem[i] = '0;
        foreach (key_mem[i]) key_mem[i] = '0;
        foreach (val_mem[i]) val_mem[i] = '0;
    endfunction

    function automatic void close_value();
        val_len[hdr_count] = nonblank;
        phase = P_HDR_DONE;
    endfunction

    // Advances the line parse by one character.
    function automatic void parse_char(logic [7:0] c);
        int s;
        s = hdr_count;
        case (phase)
            P_METHOD: begin
                if (c != CH_SP) begin
                    if (c >= CH_UPPER_A && c <= CH_UPPER_Z && pos_idx < N_METHOD - 1) begin
                        method_mem[pos_idx] = c;
                        pos_idx++;
                        method_len = pos_idx;
                    end else phase = P_ERROR;
                end else if (pos_idx != 0) begin
                    phase = P_URL;
                    pos_idx = 0;
                end
            end
            P_URL: begin
                if (c != CH_SP) begin
                    if (pos_idx < N_URL - 1) begin
                        url_mem[pos_idx] = c;
                        pos_idx++;
                        url_len = pos_idx;
                    end else phase = P_ERROR;
                end else if (pos_idx != 0) begin
                    phase = P_VERSION;
                    pos_idx = 0;
                end
            end
            P_VERSION: begin
                if (c == CH_CR || c == CH_LF) phase = P_REQ_DONE;
                else if (pos_idx < N_VER - 1) begin
                    if (c != CH_SP) begin
                        ver_mem[pos_idx] = c;
                        pos_idx++;
                        ver_len = pos_idx;
                    end
                end else phase = P_ERROR;
            end
            P_KEY: begin
                if (c == CH_SP || c == CH_CR || c == CH_LF) phase = P_ERROR;
                else if (c == CH_COLON) begin
                    if (pos_idx == 0) phase = P_ERROR;
                    else begin
                        phase = P_VALUE;
                        pos_idx = 0;
                        nonblank = 0;
                    end
                end else if (pos_idx < N_KEY - 1) begin
                    key_mem[s*N_KEY + pos_idx] = c;
                    pos_idx++;
                    key_len[s] = pos_idx;
                end else phase = P_ERROR;
            end
            P_VALUE: begin
                // Leading blanks are skipped; blanks and tabs do not move the trim mark.
                if (c == CH_SP && pos_idx == 0) begin
                end else if (c == CH_CR) phase = P_SAW_CR;
                else if (c == CH_LF) phase = P_SAW_LF;
                else if (pos_idx < N_VAL - 1) begin
                    val_mem[s*N_VAL + pos_idx] = c;
                    pos_idx++;
                    if (c != CH_SP && c != CH_TAB) nonblank = pos_idx;
                end else phase = P_ERROR;
            end
            P_SAW_CR: begin
                if (c == CH_LF) close_value();
                else phase = P_ERROR;
            end
            P_SAW_LF: begin
                if (c == CH_CR) phase = P_ERROR;
                else close_value();
            end
            default: begin
            end
        endcase
    endfunction

    // Works out the result of one accepted word, if it has one.
    function automatic bit predict_word(t_in_word w, output t_out_word r);
        int  p;
        int  sl;
        bit  slot_ok;
        r = '0;
        if (w.mode == MODE_NOP) return 0;
        if (w.mode == MODE_READ) begin
            p = w.read_pos;
            sl = w.read_header;
            slot_ok = sl < hdr_count;
            r.result_kind = 1'b1;
            r.hdr_total = 5'(hdr_count);
            case (w.read_field)
                FLD_METHOD: begin
                    r.field_length = 8'(method_len);
                    if (p < method_len) r.read_char = method_mem[p];
                end
                FLD_URL: begin
                    r.field_length = 8'(url_len);
                    if (p < url_len) r.read_char = url_mem[p];
                end
                FLD_VERSION: begin
                    r.field_length = 8'(ver_len);
                    if (p < ver_len) r.read_char = ver_mem[p];
                end
                FLD_KEY: if (slot_ok) begin
                    r.field_length = 8'(key_len[sl]);
                    if (p < key_len[sl]) r.read_char = key_mem[sl*N_KEY + p];
                end
                FLD_VALUE: if (slot_ok) begin
                    r.field_length = 8'(val_len[sl]);
                    if (p < val_len[sl]) r.read_char = val_mem[sl*N_VAL + p];
                end
                default: begin
                end
            endcase
            return 1;
        end
        if (w.line_start) begin
            pos_idx = 0;
            nonblank = 0;
            if (w.mode == MODE_REQ) begin
                method_len = 0;
                url_len = 0;
                ver_len = 0;
                hdr_count = 0;
                foreach (key_len[i]) begin
                    key_len[i] = 0;
                    val_len[i] = 0;
                end
                phase = P_METHOD;
                if (!w.end_of_line) parse_char(w.char_in);
            end else if (!w.end_of_line && (w.char_in == CH_CR || w.char_in == CH_LF)) begin
                phase = P_HDR_END;
            end else if (hdr_count >= N_SLOTS) begin
                phase = P_ERROR;
            end else begin
                key_len[hdr_count] = 0;
                phase = P_KEY;
                if (!w.end_of_line) parse_char(w.char_in);
            end
            if (!w.end_of_line) return 0;
        end else if (!w.end_of_line) begin
            parse_char(w.char_in);
            return 0;
        end
        // Terminator: the deferred LF lookahead is resolved here.
        if (phase == P_SAW_LF) close_value();
        case (phase)
            P_REQ_DONE: r.status = ST_PARSED;
            P_HDR_DONE: begin
                if (hdr_count < N_SLOTS) hdr_count++;
                r.status = ST_PARSED;
            end
            P_HDR_END: r.status = ST_HDR_END;
            default:   r.status = ST_ERROR;
        endcase
        phase = P_IDLE;
        pos_idx = 0;
        nonblank = 0;
        r.hdr_total = 5'(hdr_count);
        return 1;
    endfunction

    always @(posedge i_clk) begin
        t_out_word e;
        t_out_word r;
        if (!i_rst_n) begin
            clear_model();
            expected_words.delete();
        end else begin
            if (i_pop && !i_empty) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected result word %h", $time, i_out);
                    o_errors++;
                end else begin
                    e = expected_words.pop_front();
                    if (i_out.result_kind !== e.result_kind) begin
                        $display("%0t: result_kind expected %h got %h",
                                 $time, e.result_kind, i_out.result_kind);
                        o_errors++;
                    end
                    if (i_out.status !== e.status) begin
                        $display("%0t: status expected %h got %h", $time, e.status, i_out.status);
                        o_errors++;
                    end
                    if (i_out.hdr_total !== e.hdr_total) begin
                        $display("%0t: hdr_total expected %h got %h",
                                 $time, e.hdr_total, i_out.hdr_total);
                        o_errors++;
                    end
                    if (i_out.field_length !== e.field_length) begin
                        $display("%0t: field_length expected %h got %h",
                                 $time, e.field_length, i_out.field_length);
                        o_errors++;
                    end
                    if (i_out.read_char !== e.read_char) begin
                        $display("%0t: read_char expected %h got %h",
                                 $time, e.read_char, i_out.read_char);
                        o_errors++;
                    end
                end
            end
            if (i_push && !i_full) begin
                if (predict_word(i_in, r)) expected_words.push_back(r);
            end
        end
    end

endmodule

[tb/sv/http_request_header_parser_tb.sv]
// Top of the parser testbench: clock, reset, stimulus, idling and the verdict.
module http_request_header_parser_tb;
    import hrp_pkg::*;

    localparam int STALL_LIMIT = 2000;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      push = 1'b0;
    logic      pop = 1'b0;
    logic      full;
    logic      empty;
    t_in_word  i_data = '0;
    t_out_word o_data;
    int        errors;
    int        waiting;
    int        sent;
    int        idle_pct = 0;
    int        stall_pct = 0;
    int        quiet_cycles = 0;

    http_request_header_parser dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_data  (i_data),
        .pop     (pop),
        .empty   (empty),
        .o_data  (o_data)
    );

    hrp_line_checker checker_inst (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_full    (full),
        .i_in      (i_data),
        .i_pop     (pop),
        .i_empty   (empty),
        .i_out     (o_data),
        .o_errors  (errors),
        .o_waiting (waiting)
    );

    always #10 i_clk = ~i_clk;

    // The receiver stalls at random; the rate is set by the current phase.
    always @(negedge i_clk) begin
        pop = ($urandom_range(99) >= stall_pct);
    end

    // Any long run of cycles without a word moving on either side ends the run.
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("[http_request_header_parser] ERROR");
            $finish;
        end
    end

    // Offers one word, with an optional idle gap first, and returns once it is taken.
    task automatic put_word(logic [1:0] md, logic [7:0] ch, logic st, logic eol,
                            logic [2:0] fld, logic [3:0] slot, logic [7:0] p);
        @(negedge i_clk);
        if ($urandom_range(99) < idle_pct) begin
            push = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        i_data = '{mode: md, char_in: ch, line_start: st, end_of_line: eol,
                   read_field: fld, read_header: slot, read_pos: p};
        push = 1'b1;
        do @(posedge i_clk); while (full);
        sent++;
    endtask

    // Sends the characters of one line; a continuing word sometimes carries
    // the other line mode, which the parser must ignore.
    task automatic send_line(logic [1:0] md, byte unsigned txt[$], bit term);
        logic [1:0] m;
        foreach (txt[i]) begin
            m = (i > 0 && $urandom_range(9) == 0) ? 2'($urandom_range(0, 1)) : md;
            put_word(m, txt[i], i == 0, 1'b0, 3'($urandom), 4'($urandom), 8'($urandom));
        end
        if (term) put_word(md, 8'($urandom), txt.size() == 0, 1'b1,
                           3'($urandom), 4'($urandom), 8'($urandom));
    endtask

    task automatic read_back();
        logic [7:0] p;
        p = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 20));
        put_word(MODE_READ, 8'($urandom), 1'($urandom), 1'($urandom),
                 ($urandom_range(7) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4)),
                 4'($urandom_range(0, 15)), p);
    endtask

    task automatic request_line();
        byte unsigned t[$];
        int n;
        n = ($urandom_range(15) == 0) ? $urandom_range(14, 17) : $urandom_range(1, 7);
        repeat (n) begin
            if ($urandom_range(30) == 0) t.push_back(8'($urandom));
            else t.push_back(8'($urandom_range(CH_UPPER_A, CH_UPPER_Z)));
        end
        repeat ($urandom_range(1, 2)) t.push_back(CH_SP);
        n = ($urandom_range(40) == 0) ? $urandom_range(250, 258) : $urandom_range(1, 12);
        repeat (n) t.push_back(($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(33, 126)));
        t.push_back(CH_SP);
        n = ($urandom_range(15) == 0) ? $urandom_range(14, 17) : $urandom_range(0, 9);
        repeat (n) t.push_back(($urandom_range(6) == 0) ? CH_SP : 8'($urandom_range(33, 126)));
        if ($urandom_range(9) != 0) t.push_back($urandom_range(1) ? CH_CR : CH_LF);
        if ($urandom_range(1)) t.push_back(CH_LF);
        send_line(MODE_REQ, t, $urandom_range(19) != 0);
    endtask

    task automatic header_line();
        byte unsigned t[$];
        byte unsigned c;
        int n;
        n = ($urandom_range(30) == 0) ? $urandom_range(62, 65) : $urandom_range(1, 8);
        if ($urandom_range(25) == 0) n = 0;
        repeat (n) begin
            c = 8'($urandom);
            if ($urandom_range(40) != 0)
                while (c == CH_SP || c == CH_CR || c == CH_LF || c == CH_COLON) c = 8'($urandom);
            t.push_back(c);
        end
        t.push_back(CH_COLON);
        repeat ($urandom_range(0, 2)) t.push_back(CH_SP);
        n = ($urandom_range(50) == 0) ? $urandom_range(253, 258) : $urandom_range(0, 10);
        repeat (n) begin
            case ($urandom_range(9))
                0: c = CH_SP;
                1: c = CH_TAB;
                2: c = 8'($urandom);
                default: c = 8'($urandom_range(33, 126));
            endcase
            t.push_back(c);
        end
        repeat ($urandom_range(0, 2)) t.push_back($urandom_range(1) ? CH_SP : CH_TAB);
        case ($urandom_range(7))
            0: t.push_back(CH_LF);
            1: t.push_back(CH_CR);
            2: begin
                t.push_back(CH_LF);
                t.push_back(CH_CR);
            end
            3: begin
                t.push_back(CH_CR);
                t.push_back(8'($urandom_range(33, 126)));
            end
            default: begin
                t.push_back(CH_CR);
                t.push_back(CH_LF);
            end
        endcase
        // Now and then a line is dropped by starting another one over it.
        send_line(MODE_HDR, t, $urandom_range(24) != 0);
    endtask

    // One request: request line, headers, the blank line, then reads and noise.
    task automatic request_block();
        byte unsigned t[$];
        int n;
        request_line();
        n = ($urandom_range(9) == 0) ? 17 : $urandom_range(0, 5);
        repeat (n) header_line();
        t = '{CH_CR, CH_LF};
        if ($urandom_range(1)) t = '{CH_LF};
        send_line(MODE_HDR, t, 1'b1);
        repeat ($urandom_range(2, 8)) read_back();
        repeat ($urandom_range(0, 3))
            put_word(2'($urandom), 8'($urandom), 1'($urandom), 1'($urandom),
                     3'($urandom), 4'($urandom), 8'($urandom));
    endtask

    initial begin
        byte unsigned t[$];
        sent = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part: the corner cases of the line protocol.
        put_word(MODE_REQ, 8'h00, 1'b0, 1'b1, FLD_METHOD, 4'd0, 8'd0);   // terminator, no line
        put_word(MODE_HDR, 8'hFF, 1'b0, 1'b0, FLD_METHOD, 4'd0, 8'd0);   // stray character
        put_word(MODE_HDR, 8'h00, 1'b1, 1'b1, FLD_METHOD, 4'd0, 8'd0);   // empty line
        put_word(MODE_NOP, 8'hFF, 1'b1, 1'b1, 3'd7, 4'hF, 8'hFF);        // unused mode
        t = '{"G", " ", "/", 8'h00, " ", "V", CH_CR, CH_LF};
        send_line(MODE_REQ, t, 1'b1);
        t = '{"K", ":", " ", "v", CH_TAB, CH_SP, CH_CR, CH_LF};
        send_line(MODE_HDR, t, 1'b1);
        put_word(MODE_READ, 8'h00, 1'b0, 1'b0, FLD_VALUE, 4'd0, 8'd0);
        put_word(MODE_READ, 8'h00, 1'b0, 1'b0, FLD_URL, 4'd0, 8'd1);
        put_word(MODE_READ, 8'h00, 1'b0, 1'b0, FLD_KEY, 4'd15, 8'd255);
        put_word(MODE_READ, 8'h00, 1'b0, 1'b0, 3'd7, 4'd0, 8'd0);

        // Random part in four idling phases.
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct  = (ph == 1) ? 53 : (ph == 3) ? 30 : 0;
            stall_pct = (ph == 2) ? 53 : (ph == 3) ? 30 : 0;
            while (sent < 150 * (ph + 1)) request_block();
            if (ph == 1) begin
                // Hold the sender back until the result queue has drained.
                @(negedge i_clk);
                push = 1'b0;
                while (waiting != 0) @(negedge i_clk);
            end
        end

        @(negedge i_clk);
        push = 1'b0;
        while (waiting != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (errors == 0) $display("[http_request_header_parser] OK");
        else $display("[http_request_header_parser] ERROR");
        $finish;
    end

endmodule

[filelist.f]
design/hrp_pkg.sv
design/hrp_ram.sv
design/hrp_fifo.sv
design/hrp_front.sv
design/hrp_back.sv
design/http_request_header_parser.sv
tb/sv/hrp_line_checker.sv
tb/sv/http_request_header_parser_tb.sv
